### hw/rtl/ckmc_pkg.sv
// ----------------------------------------------------------------------------
// ckmc_pkg: shared types and constants for the color key mask centroid block
// Holds field widths, frame limits, register indexes and the word formats
// that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ckmc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 13;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CEN_W  = 12;
  localparam int CNT_W  = 25;
  localparam int SUM_W  = 36;
  localparam int ITER_W = $clog2(CEN_W);

  localparam int HIT_CAP = MAX_WIDTH * MAX_HEIGHT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [PIX_W-1:0] KEY_RED_RST   = PIX_W'(208);
  localparam logic [PIX_W-1:0] KEY_GREEN_RST = PIX_W'(138);
  localparam logic [PIX_W-1:0] KEY_BLUE_RST  = PIX_W'(116);
  localparam logic [PIX_W-1:0] TOL_RST       = PIX_W'(25);
  localparam logic [FW_W-1:0]  FW_RST        = FW_W'(640);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_RED     = 3'd0,
    CFG_KEY_GREEN   = 3'd1,
    CFG_KEY_BLUE    = 3'd2,
    CFG_TOLERANCE   = 3'd3,
    CFG_FRAME_WIDTH = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [PIX_W-1:0] key_red;
    logic [PIX_W-1:0] key_green;
    logic [PIX_W-1:0] key_blue;
    logic [PIX_W-1:0] tolerance;
    logic [FW_W-1:0]  frame_width;
  } cfg_t;

  // One word per accepted pixel. Sums and count are filled in on the last
  // pixel of a frame only and are zero otherwise.
  typedef struct packed {
    logic             mask;
    logic             last;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
  } entry_t;

  function automatic logic near_key(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] key,
                                    logic [PIX_W-1:0] tol);
    logic [PIX_W-1:0] diff;
    diff = (pix >= key) ? (pix - key) : (key - pix);
    return diff <= tol;
  endfunction

endpackage

### hw/rtl/ckmc_front.sv
// ----------------------------------------------------------------------------
// ckmc_front: pixel classification and frame accumulation
// Marks pixels near the key color, tracks the raster position and keeps the
// marked count and position sums. Emits one queue word per pixel.
// ----------------------------------------------------------------------------
module ckmc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ckmc_pkg::cfg_t             cfg_i,
  input  logic                       take_i,
  input  logic [ckmc_pkg::PIX_W-1:0] red_i,
  input  logic [ckmc_pkg::PIX_W-1:0] green_i,
  input  logic [ckmc_pkg::PIX_W-1:0] blue_i,
  input  logic                       last_pixel_i,
  output ckmc_pkg::entry_t           entry_o
);

  logic [ckmc_pkg::COL_W-1:0] column_q, column_d;
  logic [ckmc_pkg::ROW_W-1:0] row_q, row_d;
  logic [ckmc_pkg::CNT_W-1:0] hit_count_q, hit_count_d;
  logic [ckmc_pkg::SUM_W-1:0] sum_x_q, sum_x_d;
  logic [ckmc_pkg::SUM_W-1:0] sum_y_q, sum_y_d;

  logic                      hit;
  logic                      add;
  logic [ckmc_pkg::FW_W-1:0] act_width;
  logic [ckmc_pkg::FW_W-1:0] col_inc;
  logic [ckmc_pkg::CNT_W-1:0] cnt_new;
  logic [ckmc_pkg::SUM_W-1:0] sx_new;
  logic [ckmc_pkg::SUM_W-1:0] sy_new;

  assign hit = ckmc_pkg::near_key(red_i, cfg_i.key_red, cfg_i.tolerance) &&
               ckmc_pkg::near_key(green_i, cfg_i.key_green, cfg_i.tolerance) &&
               ckmc_pkg::near_key(blue_i, cfg_i.key_blue, cfg_i.tolerance);

  // Once the count reaches the cap, marked pixels no longer accumulate.
  assign add = hit && (hit_count_q < ckmc_pkg::CNT_W'(ckmc_pkg::HIT_CAP));

  assign cnt_new = add ? hit_count_q + ckmc_pkg::CNT_W'(1) : hit_count_q;
  assign sx_new  = add ? sum_x_q + ckmc_pkg::SUM_W'(column_q) : sum_x_q;
  assign sy_new  = add ? sum_y_q + ckmc_pkg::SUM_W'(row_q) : sum_y_q;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      act_width = ckmc_pkg::FW_W'(1);
    end else if (cfg_i.frame_width > ckmc_pkg::FW_W'(ckmc_pkg::MAX_WIDTH)) begin
      act_width = ckmc_pkg::FW_W'(ckmc_pkg::MAX_WIDTH);
    end else begin
      act_width = cfg_i.frame_width;
    end
  end

  assign col_inc = ckmc_pkg::FW_W'(column_q) + ckmc_pkg::FW_W'(1);

  always_comb begin
    column_d    = column_q;
    row_d       = row_q;
    hit_count_d = hit_count_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    if (take_i) begin
      if (last_pixel_i) begin
        column_d    = '0;
        row_d       = '0;
        hit_count_d = '0;
        sum_x_d     = '0;
        sum_y_d     = '0;
      end else begin
        hit_count_d = cnt_new;
        sum_x_d     = sx_new;
        sum_y_d     = sy_new;
        // A narrowed width within a frame wraps the column at once.
        if (col_inc >= act_width) begin
          column_d = '0;
          if (row_q != ckmc_pkg::ROW_W'(ckmc_pkg::MAX_HEIGHT - 1)) begin
            row_d = row_q + ckmc_pkg::ROW_W'(1);
          end
        end else begin
          column_d = col_inc[ckmc_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_q       <= '0;
      hit_count_q <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
    end else begin
      column_q    <= column_d;
      row_q       <= row_d;
      hit_count_q <= hit_count_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
    end
  end

  always_comb begin
    entry_o.mask  = hit;
    entry_o.last  = last_pixel_i;
    entry_o.sum_x = last_pixel_i ? sx_new : '0;
    entry_o.sum_y = last_pixel_i ? sy_new : '0;
    entry_o.count = last_pixel_i ? cnt_new : '0;
  end

endmodule

### hw/rtl/ckmc_fifo.sv
// ----------------------------------------------------------------------------
// ckmc_fifo: short word queue between front end and back end
// Register based first-in first-out buffer; the head word is always visible.
// ----------------------------------------------------------------------------
module ckmc_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  ckmc_pkg::entry_t wdata_i,
  input  logic             rd_i,
  output ckmc_pkg::entry_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(ckmc_pkg::QUEUE_DEPTH);
  localparam int FILL_W = PTR_W + 1;

  ckmc_pkg::entry_t slot_q [ckmc_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_wr;
  logic              do_rd;

  assign full_o  = (fill_q == FILL_W'(ckmc_pkg::QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_wr && !do_rd) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/ckmc_back.sv
// ----------------------------------------------------------------------------
// ckmc_back: result formation and centroid division
// Passes ordinary pixel words to the output register and runs two restoring
// dividers side by side for the centroid of each frame with marked pixels.
// ----------------------------------------------------------------------------
module ckmc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ckmc_pkg::entry_t            entry_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic                        mask_on_o,
  output logic                        frame_done_o,
  output logic [ckmc_pkg::CEN_W-1:0]  centroid_x_o,
  output logic [ckmc_pkg::CEN_W-1:0]  centroid_y_o,
  output logic [ckmc_pkg::CNT_W-1:0]  marked_count_o,
  output logic                        no_marked_o
);

  localparam int CEN_W  = ckmc_pkg::CEN_W;
  localparam int CNT_W  = ckmc_pkg::CNT_W;
  localparam int SUM_W  = ckmc_pkg::SUM_W;
  localparam int ITER_W = ckmc_pkg::ITER_W;

  ckmc_pkg::back_state_e state_q, state_d;

  logic             start_div;
  logic             step_div;
  logic             load_direct;
  logic             load_div;
  logic             out_free;

  logic [ITER_W-1:0] iter_q;
  logic [CNT_W-1:0]  divisor_q;
  logic [CNT_W-1:0]  rem_x_q, rem_y_q;
  logic [CEN_W-1:0]  dvd_x_q, dvd_y_q;
  logic [CEN_W-1:0]  quo_x_q, quo_y_q;
  logic              mask_hold_q;

  logic [CNT_W:0]    sh_x, sh_y;
  logic              ge_x, ge_y;
  logic [CNT_W:0]    dif_x, dif_y;

  logic              res_valid_q;

  assign out_free = !res_valid_q || pop_i;
  assign empty_o  = !res_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ckmc_pkg::BK_IDLE: begin
        if (!q_empty_i && out_free && entry_i.last && entry_i.count != '0) begin
          state_d = ckmc_pkg::BK_DIV;
        end
      end
      ckmc_pkg::BK_DIV: begin
        if (iter_q == ITER_W'(CEN_W - 1)) begin
          state_d = ckmc_pkg::BK_DONE;
        end
      end
      ckmc_pkg::BK_DONE: begin
        if (out_free) begin
          state_d = ckmc_pkg::BK_IDLE;
        end
      end
      default: state_d = ckmc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o     = 1'b0;
    start_div   = 1'b0;
    step_div    = 1'b0;
    load_direct = 1'b0;
    load_div    = 1'b0;
    case (state_q)
      ckmc_pkg::BK_IDLE: begin
        if (!q_empty_i && out_free) begin
          q_pop_o = 1'b1;
          if (entry_i.last && entry_i.count != '0) begin
            start_div = 1'b1;
          end else begin
            load_direct = 1'b1;
          end
        end
      end
      ckmc_pkg::BK_DIV:  step_div = 1'b1;
      ckmc_pkg::BK_DONE: load_div = out_free;
      default: ;
    endcase
  end

  // The mean of positions below 4096 fits the quotient in CEN_W bits, so the
  // partial remainder starts from the dividend's upper bits and one quotient
  // bit is produced per cycle.
  assign sh_x  = {rem_x_q, dvd_x_q[CEN_W-1]};
  assign sh_y  = {rem_y_q, dvd_y_q[CEN_W-1]};
  assign dif_x = sh_x - {1'b0, divisor_q};
  assign dif_y = sh_y - {1'b0, divisor_q};
  assign ge_x  = sh_x >= {1'b0, divisor_q};
  assign ge_y  = sh_y >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ckmc_pkg::BK_IDLE;
      iter_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_div) begin
        iter_q <= '0;
      end else if (step_div) begin
        iter_q <= iter_q + ITER_W'(1);
      end
      if (load_direct || load_div) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_div) begin
      divisor_q   <= entry_i.count;
      mask_hold_q <= entry_i.mask;
      rem_x_q     <= CNT_W'(entry_i.sum_x[SUM_W-1:CEN_W]);
      rem_y_q     <= CNT_W'(entry_i.sum_y[SUM_W-1:CEN_W]);
      dvd_x_q     <= entry_i.sum_x[CEN_W-1:0];
      dvd_y_q     <= entry_i.sum_y[CEN_W-1:0];
      quo_x_q     <= '0;
      quo_y_q     <= '0;
    end else if (step_div) begin
      rem_x_q <= ge_x ? dif_x[CNT_W-1:0] : sh_x[CNT_W-1:0];
      rem_y_q <= ge_y ? dif_y[CNT_W-1:0] : sh_y[CNT_W-1:0];
      dvd_x_q <= {dvd_x_q[CEN_W-2:0], 1'b0};
      dvd_y_q <= {dvd_y_q[CEN_W-2:0], 1'b0};
      quo_x_q <= {quo_x_q[CEN_W-2:0], ge_x};
      quo_y_q <= {quo_y_q[CEN_W-2:0], ge_y};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_direct) begin
      mask_on_o      <= entry_i.mask;
      frame_done_o   <= entry_i.last;
      centroid_x_o   <= '0;
      centroid_y_o   <= '0;
      marked_count_o <= entry_i.count;
      no_marked_o    <= entry_i.last && (entry_i.count == '0);
    end else if (load_div) begin
      mask_on_o      <= mask_hold_q;
      frame_done_o   <= 1'b1;
      centroid_x_o   <= quo_x_q;
      centroid_y_o   <= quo_y_q;
      marked_count_o <= divisor_q;
      no_marked_o    <= 1'b0;
    end
  end

endmodule

### hw/rtl/color_key_mask_centroid_top.sv
// ----------------------------------------------------------------------------
// color_key_mask_centroid_top: color key mask with per-frame centroid
// Marks pixels close to a key color and reports the mean position of the
// marked pixels at the end of every frame.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------
//  pixel in | push_i / full_o      | red_i, green_i, blue_i, last_pixel_i
//  result   | pop_i / empty_o      | mask_on_o, frame_done_o, centroid_x_o,
//           |                      | centroid_y_o, marked_count_o, no_marked_o
//  config   | cfg_we_i             | cfg_addr_i, cfg_wdata_i
//
// A pixel is classified and accumulated when accepted and its result is
// registered after the queue. Ordinary pixels flow at one word per cycle
// unless a result waits or a division runs. The last pixel of a frame with
// marked pixels holds the back end to load, run the centroid dividers and
// write the result; a four-word queue absorbs that and full_o rises only when
// it fills. Reset restores register defaults and empties queue and result.
module color_key_mask_centroid_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ckmc_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [ckmc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [ckmc_pkg::PIX_W-1:0]      red_i,
  input  logic [ckmc_pkg::PIX_W-1:0]      green_i,
  input  logic [ckmc_pkg::PIX_W-1:0]      blue_i,
  input  logic                            last_pixel_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic                            mask_on_o,
  output logic                            frame_done_o,
  output logic [ckmc_pkg::CEN_W-1:0]      centroid_x_o,
  output logic [ckmc_pkg::CEN_W-1:0]      centroid_y_o,
  output logic [ckmc_pkg::CNT_W-1:0]      marked_count_o,
  output logic                            no_marked_o
);

  ckmc_pkg::cfg_t   cfg_q;
  ckmc_pkg::entry_t front_word;
  ckmc_pkg::entry_t head_word;
  logic             take;
  logic             q_pop;
  logic             q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_red     <= ckmc_pkg::KEY_RED_RST;
      cfg_q.key_green   <= ckmc_pkg::KEY_GREEN_RST;
      cfg_q.key_blue    <= ckmc_pkg::KEY_BLUE_RST;
      cfg_q.tolerance   <= ckmc_pkg::TOL_RST;
      cfg_q.frame_width <= ckmc_pkg::FW_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ckmc_pkg::CFG_KEY_RED:     cfg_q.key_red     <= cfg_wdata_i[ckmc_pkg::PIX_W-1:0];
        ckmc_pkg::CFG_KEY_GREEN:   cfg_q.key_green   <= cfg_wdata_i[ckmc_pkg::PIX_W-1:0];
        ckmc_pkg::CFG_KEY_BLUE:    cfg_q.key_blue    <= cfg_wdata_i[ckmc_pkg::PIX_W-1:0];
        ckmc_pkg::CFG_TOLERANCE:   cfg_q.tolerance   <= cfg_wdata_i[ckmc_pkg::PIX_W-1:0];
        ckmc_pkg::CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_wdata_i[ckmc_pkg::FW_W-1:0];
        default: ;
      endcase
    end
  end

  assign take = push_i && !full_o;

  ckmc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .take_i       (take),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .entry_o      (front_word)
  );

  ckmc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (take),
    .wdata_i (front_word),
    .rd_i    (q_pop),
    .rdata_o (head_word),
    .full_o  (full_o),
    .empty_o (q_empty)
  );

  ckmc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (head_word),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .mask_on_o      (mask_on_o),
    .frame_done_o   (frame_done_o),
    .centroid_x_o   (centroid_x_o),
    .centroid_y_o   (centroid_y_o),
    .marked_count_o (marked_count_o),
    .no_marked_o    (no_marked_o)
  );

endmodule

### hw/rtl/ckmc_checker.sv
// ----------------------------------------------------------------------------
// ckmc_checker: port level checks for the color key mask centroid block
// Watches the result channel and the frame summary fields it carries.
// ----------------------------------------------------------------------------
module ckmc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            empty_o,
  input logic                            pop_i,
  input logic                            mask_on_o,
  input logic                            frame_done_o,
  input logic [ckmc_pkg::CEN_W-1:0]      centroid_x_o,
  input logic [ckmc_pkg::CEN_W-1:0]      centroid_y_o,
  input logic [ckmc_pkg::CNT_W-1:0]      marked_count_o,
  input logic                            no_marked_o
);

  // Summary fields are zero on every word that does not close a frame.
  a_mid_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !frame_done_o) |->
      (centroid_x_o == '0 && centroid_y_o == '0 && marked_count_o == '0 && !no_marked_o))
    else $error("summary fields set on a word inside a frame");

  // An empty frame reports no count and a zero centroid.
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && no_marked_o) |->
      (frame_done_o && marked_count_o == '0 && centroid_x_o == '0 && centroid_y_o == '0))
    else $error("empty frame word carries a count or centroid");

  // A frame that is not flagged empty must report at least one marked pixel.
  a_count_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && frame_done_o && !no_marked_o) |-> (marked_count_o != '0))
    else $error("frame closed with zero count but no empty flag");

  // A waiting result stays put until it is taken.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=>
      (!empty_o && $stable(frame_done_o) && $stable(mask_on_o) && $stable(marked_count_o)))
    else $error("result word changed while waiting");

endmodule

bind color_key_mask_centroid_top ckmc_checker u_ckmc_checker (.*);
